### rtl/core/adss_pkg.sv
// Package for the additive oscillator bank: sizes, codes, sequencer state,
// control bundle and the quarter-wave sine table built at elaboration.
// No dependencies.
package adss_pkg;

  localparam int MAX_PARTIALS = 16;
  localparam int PIDX_W       = $clog2(MAX_PARTIALS);
  localparam int PCNT_W       = PIDX_W + 1;
  localparam int SINE_DEPTH   = 256;
  localparam int SINE_AW      = $clog2(SINE_DEPTH);
  localparam int SUM_W        = 32 + PIDX_W;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_GEN  = 1'b1;

  localparam logic CFG_BASE_INC    = 1'b0;
  localparam logic CFG_PARTIAL_CNT = 1'b1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INC,
    S_AMP,
    S_DONE
  } adss_state_t;

  typedef struct packed {
    logic              load_we;
    logic              start;
    logic              step_inc;
    logic              step_amp;
    logic              add_prod;
    logic              emit;
    logic              clear;
    logic [PIDX_W-1:0] idx;
  } adss_ctrl_t;

  typedef logic [15:0] sine_rom_t [SINE_DEPTH];

  function automatic sine_rom_t build_sine();
    sine_rom_t   rom;
    logic [63:0] x;
    logic [63:0] term;
    longint      sum;
    int          k;
    int          n;
    for (k = 0; k < SINE_DEPTH; k++) begin
      x    = (HALF_PI_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_DEPTH);
      term = x;
      sum  = longint'(x);
      for (n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        // series divisor (2n)(2n+1)
        case (n)
          1:       term = term / 64'd6;
          2:       term = term / 64'd20;
          3:       term = term / 64'd42;
          4:       term = term / 64'd72;
          5:       term = term / 64'd110;
          6:       term = term / 64'd156;
          7:       term = term / 64'd210;
          default: term = term / 64'd272;
        endcase
        if ((n % 2) == 1) begin
          sum = sum - longint'(term);
        end else begin
          sum = sum + longint'(term);
        end
      end
      if (sum < 0) begin
        sum = 0;
      end
      if (sum > longint'(ONE_Q30)) begin
        sum = longint'(ONE_Q30);
      end
      rom[k] = 16'(((64'(sum) * 64'd32767) + (ONE_Q30 >> 1)) >> 30);
    end
    return rom;
  endfunction

  localparam sine_rom_t SINE_ROM = build_sine();

endpackage

### rtl/core/adss_partial_store.sv
// Partial entry store: ratio, amplitude and offset tables plus the
// per-partial phase accumulators. Depends on adss_pkg.
module adss_partial_store (
  input  logic                         clk,
  input  logic                         rst_n,
  input  adss_pkg::adss_ctrl_t         ctrl,
  input  logic [3:0]                   wr_index,
  input  logic [15:0]                  wr_ratio,
  input  logic [15:0]                  wr_amplitude,
  input  logic [15:0]                  wr_offset,
  input  logic [31:0]                  inc,
  output logic [15:0]                  rd_ratio,
  output logic [15:0]                  rd_amplitude,
  output logic [15:0]                  rd_offset,
  output logic [31:0]                  rd_acc
);
  import adss_pkg::*;

  logic [15:0] ratio_r  [MAX_PARTIALS];
  logic [15:0] amp_r    [MAX_PARTIALS];
  logic [15:0] offset_r [MAX_PARTIALS];
  logic [31:0] acc_r    [MAX_PARTIALS];
  logic        wr_ok;
  logic [PIDX_W-1:0] wr_sel;

  assign wr_ok  = 32'(wr_index) < MAX_PARTIALS;
  assign wr_sel = PIDX_W'(wr_index);

  always_ff @(posedge clk) begin
    if (ctrl.load_we && wr_ok) begin
      ratio_r[wr_sel]  <= wr_ratio;
      amp_r[wr_sel]    <= wr_amplitude;
      offset_r[wr_sel] <= wr_offset;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctrl.clear) begin
      for (int i = 0; i < MAX_PARTIALS; i++) begin
        acc_r[i] <= '0;
      end
    end else if (ctrl.step_amp) begin
      acc_r[ctrl.idx] <= acc_r[ctrl.idx] + inc;
    end
  end

  assign rd_ratio     = ratio_r[ctrl.idx];
  assign rd_amplitude = amp_r[ctrl.idx];
  assign rd_offset    = offset_r[ctrl.idx];
  assign rd_acc       = acc_r[ctrl.idx];

endmodule

### rtl/core/adss_mac_unit.sv
// Shared multiplier datapath: phase increment, sine lookup, amplitude
// product, running sum and output saturation. Depends on adss_pkg.
module adss_mac_unit (
  input  logic                 clk,
  input  adss_pkg::adss_ctrl_t ctrl,
  input  logic [31:0]          base_inc,
  input  logic [15:0]          ratio,
  input  logic [15:0]          amplitude,
  input  logic [15:0]          offset,
  input  logic [31:0]          acc,
  input  logic [15:0]          prior,
  output logic [31:0]          inc,
  output logic [15:0]          sample
);
  import adss_pkg::*;

  logic [31:0]              phase;
  logic [1:0]               quad;
  logic [SINE_AW-1:0]       rom_idx;
  logic [15:0]              mag;
  logic signed [16:0]       sine;
  logic signed [16:0]       sine_r;
  logic signed [32:0]       mul_a;
  logic signed [16:0]       mul_b;
  logic signed [49:0]       prod;
  logic [47:0]              prod_r;
  logic signed [SUM_W-1:0]  sum_r;
  logic signed [SUM_W-1:0]  sum_init;
  logic signed [SUM_W-1:0]  sum_sel;
  logic                     in_range;

  assign phase   = acc + {offset, 16'h0000};
  assign quad    = phase[31:30];
  assign rom_idx = quad[0] ? ~phase[29 -: SINE_AW] : phase[29 -: SINE_AW];
  assign mag     = SINE_ROM[rom_idx];
  assign sine    = quad[1] ? -signed'({1'b0, mag}) : signed'({1'b0, mag});

  assign mul_a = ctrl.step_amp ? signed'({{17{amplitude[15]}}, amplitude})
                               : signed'({1'b0, base_inc});
  assign mul_b = ctrl.step_amp ? sine_r : signed'({1'b0, ratio});
  assign prod  = mul_a * mul_b;

  assign inc = prod_r[39:8];

  assign sum_init = signed'({{(SUM_W-31){prior[15]}}, prior, 15'h0000});
  assign sum_sel  = ctrl.add_prod
                  ? sum_r + signed'({{(SUM_W-32){prod_r[31]}}, prod_r[31:0]})
                  : sum_r;

  assign in_range = (&sum_sel[SUM_W-1:30]) || !(|sum_sel[SUM_W-1:30]);

  always_comb begin
    if (in_range) begin
      sample = sum_sel[30:15];
    end else if (sum_sel[SUM_W-1]) begin
      sample = 16'h8000;
    end else begin
      sample = 16'h7fff;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.step_inc) begin
      sine_r <= sine;
    end
    if (ctrl.step_inc || ctrl.step_amp) begin
      prod_r <= prod[47:0];
    end
    if (ctrl.start) begin
      sum_r <= sum_init;
    end else if (ctrl.step_inc) begin
      sum_r <= sum_sel;
    end
  end

endmodule

### rtl/core/adss_seq.sv
// Sequencer: walks the active partials, two multiplier steps each, then
// hands the finished sum to the output register. Depends on adss_pkg.
module adss_seq (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_fire,
  input  logic                      in_action,
  input  logic [adss_pkg::PCNT_W-1:0] active,
  input  logic                      last_r,
  input  logic                      out_busy,
  output logic                      in_ready,
  output adss_pkg::adss_ctrl_t      ctrl
);
  import adss_pkg::*;

  adss_state_t       state_r;
  adss_state_t       state_nxt;
  logic [PCNT_W-1:0] m_r;
  logic [PCNT_W-1:0] m_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      m_r     <= '0;
    end else begin
      state_r <= state_nxt;
      m_r     <= m_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    m_nxt         = m_r;
    in_ready      = 1'b0;
    ctrl          = '0;
    ctrl.idx      = m_r[PIDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_fire) begin
          if (in_action == ACT_GEN) begin
            ctrl.start = 1'b1;
            m_nxt      = '0;
            state_nxt  = (active == '0) ? S_DONE : S_INC;
          end else begin
            ctrl.load_we = 1'b1;
          end
        end
      end
      S_INC: begin
        ctrl.step_inc = 1'b1;
        ctrl.add_prod = (m_r != '0);
        state_nxt     = S_AMP;
      end
      S_AMP: begin
        ctrl.step_amp = 1'b1;
        m_nxt         = m_r + 1'b1;
        state_nxt     = (m_r + 1'b1 == active) ? S_DONE : S_INC;
      end
      S_DONE: begin
        ctrl.add_prod = (active != '0);
        if (!out_busy) begin
          ctrl.emit  = 1'b1;
          ctrl.clear = last_r;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

### rtl/core/additive_sine_synth_core.sv
// Top level of the additive oscillator bank: ports, configuration
// registers, sample counter and output register. Uses adss_pkg, adss_seq,
// adss_partial_store and adss_mac_unit.
//
//   port group   dir   tdata                                   side band
//   in_*         in    partial_index, ratio, amplitude,        tuser: action
//                      phase_offset, prior_sample              tlast: last_sample
//   out_*        out   sample, sample_index                    -
//   cfg_*        in    index 0 base_increment, 1 partial_count -
//
// For each sample one multiplier serves the increment and the amplitude
// product of each active partial in turn. Reset clears the accumulators,
// the counter and both registers; partial entries hold nothing until loaded.
// A stalled output holds the finished sample in the last step.
module additive_sine_synth_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [71:0] in_tdata,   // partial_index, ratio, amplitude, phase_offset,
                                  // prior_sample, zero pad
  input  logic        in_tuser,   // action
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // sample, sample_index
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);
  import adss_pkg::*;

  adss_ctrl_t        ctrl;
  logic              in_fire;
  logic              out_busy;
  logic [31:0]       base_inc_r;
  logic [4:0]        partial_cnt_r;
  logic [PCNT_W-1:0] active;
  logic              last_r;
  logic [31:0]       count_r;
  logic              out_valid_r;
  logic [15:0]       out_sample_r;
  logic [31:0]       out_index_r;
  logic [15:0]       rd_ratio;
  logic [15:0]       rd_amplitude;
  logic [15:0]       rd_offset;
  logic [31:0]       rd_acc;
  logic [31:0]       inc;
  logic [15:0]       sample;
  logic [15:0]       prior_r;

  assign in_fire  = in_tvalid && in_tready;
  assign out_busy = out_valid_r && !out_tready;
  assign active   = (32'(partial_cnt_r) > MAX_PARTIALS) ? PCNT_W'(MAX_PARTIALS)
                                                        : PCNT_W'(partial_cnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_inc_r    <= '0;
      partial_cnt_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_BASE_INC:    base_inc_r    <= cfg_wdata;
        CFG_PARTIAL_CNT: partial_cnt_r <= cfg_wdata[4:0];
        default:         base_inc_r    <= base_inc_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      last_r  <= in_tlast;
      prior_r <= in_tdata[67:52];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.emit) begin
        count_r     <= last_r ? '0 : count_r + 32'd1;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.emit) begin
      out_sample_r <= sample;
      out_index_r  <= count_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_index_r, out_sample_r};

  adss_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fire   (in_fire),
    .in_action (in_tuser),
    .active    (active),
    .last_r    (last_r),
    .out_busy  (out_busy),
    .in_ready  (in_tready),
    .ctrl      (ctrl)
  );

  adss_partial_store u_store (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctrl         (ctrl),
    .wr_index     (in_tdata[3:0]),
    .wr_ratio     (in_tdata[19:4]),
    .wr_amplitude (in_tdata[35:20]),
    .wr_offset    (in_tdata[51:36]),
    .inc          (inc),
    .rd_ratio     (rd_ratio),
    .rd_amplitude (rd_amplitude),
    .rd_offset    (rd_offset),
    .rd_acc       (rd_acc)
  );

  adss_mac_unit u_mac (
    .clk       (clk),
    .ctrl      (ctrl),
    .base_inc  (base_inc_r),
    .ratio     (rd_ratio),
    .amplitude (rd_amplitude),
    .offset    (rd_offset),
    .acc       (rd_acc),
    .prior     (ctrl.start ? in_tdata[67:52] : prior_r),
    .inc       (inc),
    .sample    (sample)
  );

endmodule

### tb/sv/tb_additive_sine_synth_core.sv
`timescale 1ns / 1ps
// Self-checking bench for additive_sine_synth_core: queue-fed stream driver,
// output monitor and an in-bench oscillator-bank predictor with its own sine table.
// Depends on adss_pkg and the core RTL only.
module tb_additive_sine_synth_core;
  import adss_pkg::*;

  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 60;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 143;

  localparam logic [63:0] QUARTER_TURN_Q30 = 64'd1686629713;
  localparam logic [63:0] UNIT_Q30         = 64'd1073741824;

  typedef struct {
    logic        action;
    logic [3:0]  pidx;
    logic [15:0] ratio;
    logic [15:0] amp;
    logic [15:0] offset;
    logic [15:0] prior;
    logic        last;
  } synth_item_t;

  typedef struct {
    logic [15:0] sample;
    logic [31:0] index;
  } synth_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [71:0] in_tdata   = '0;
  logic        in_tuser   = 1'b0;
  logic        in_tlast   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [47:0] out_tdata;
  logic        cfg_we     = 1'b0;
  logic        cfg_index  = 1'b0;
  logic [31:0] cfg_wdata  = '0;

  synth_item_t   pending_items[$];
  synth_result_t expected_samples[$];
  synth_item_t   drive_item;
  synth_item_t   seen_item;
  synth_result_t want;

  logic [31:0] model_base_inc;
  logic [4:0]  model_count;
  logic [15:0] ratio_mem[MAX_PARTIALS];
  logic [15:0] amp_mem[MAX_PARTIALS];
  logic [15:0] offset_mem[MAX_PARTIALS];
  logic [31:0] phase_acc[MAX_PARTIALS];
  logic [31:0] model_counter;
  logic [15:0] sine_quarter[SINE_DEPTH];

  int fail_count     = 0;
  int queued_count   = 0;
  int accepted_count = 0;
  int idle_cycles    = 0;
  int in_gap         = 0;
  int out_gap        = 0;
  bit quiet          = 1'b0;

  additive_sine_synth_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic void build_quarter_wave();
    longint unsigned x;
    longint unsigned term;
    longint          acc;
    int              k;
    int              n;
    for (k = 0; k < SINE_DEPTH; k++) begin
      x    = (QUARTER_TURN_Q30 * 64'(2 * k + 1)) / 64'(2 * SINE_DEPTH);
      term = x;
      acc  = longint'(x);
      for (n = 1; n <= 8; n++) begin
        term = (term * x) >> 30;
        term = (term * x) >> 30;
        term = term / 64'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > longint'(UNIT_Q30)) begin
        acc = longint'(UNIT_Q30);
      end
      sine_quarter[k] = 16'((64'(acc) * 64'd32767 + (UNIT_Q30 >> 1)) >> 30);
    end
  endfunction

  function automatic longint quarter_sine_lookup(logic [31:0] p);
    longint unsigned pos;
    longint          mag;
    pos = ({34'h0, p[29:0]} * 64'(SINE_DEPTH)) >> 30;
    if (p[30]) begin
      pos = 64'(SINE_DEPTH - 1) - pos;
    end
    mag = longint'(sine_quarter[pos]);
    return p[31] ? -mag : mag;
  endfunction

  task automatic apply_item(input synth_item_t it);
    int            active;
    int            m;
    longint        total;
    logic [31:0]   p;
    logic [63:0]   prod;
    synth_result_t r;
    if (it.action == ACT_LOAD) begin
      ratio_mem[it.pidx]  = it.ratio;
      amp_mem[it.pidx]    = it.amp;
      offset_mem[it.pidx] = it.offset;
      return;
    end
    active = (model_count > MAX_PARTIALS) ? MAX_PARTIALS : int'(model_count);
    total  = longint'($signed(it.prior)) * 32768;
    for (m = 0; m < active; m++) begin
      p     = phase_acc[m] + {offset_mem[m], 16'h0000};
      total = total + longint'($signed(amp_mem[m])) * quarter_sine_lookup(p);
      prod  = {32'h0, model_base_inc} * {48'h0, ratio_mem[m]};
      phase_acc[m] = phase_acc[m] + prod[39:8];
    end
    total = total >>> 15;
    if (total > 32767) begin
      total = 32767;
    end
    if (total < -32768) begin
      total = -32768;
    end
    r.sample = total[15:0];
    r.index  = model_counter;
    expected_samples.push_back(r);
    model_counter = model_counter + 1;
    if (it.last) begin
      for (m = 0; m < MAX_PARTIALS; m++) begin
        phase_acc[m] = '0;
      end
      model_counter = '0;
    end
  endtask

  task automatic queue_load(input logic [3:0] pidx, input logic [15:0] ratio,
                            input logic [15:0] amp, input logic [15:0] offset);
    synth_item_t it;
    it.action = ACT_LOAD;
    it.pidx   = pidx;
    it.ratio  = ratio;
    it.amp    = amp;
    it.offset = offset;
    it.prior  = 16'($urandom_range(0, 65535));
    it.last   = 1'($urandom_range(0, 1));
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic queue_gen(input logic [15:0] prior, input logic last);
    synth_item_t it;
    it.action = ACT_GEN;
    it.pidx   = 4'($urandom_range(0, 15));
    it.ratio  = 16'($urandom_range(0, 65535));
    it.amp    = 16'($urandom_range(0, 65535));
    it.offset = 16'($urandom_range(0, 65535));
    it.prior  = prior;
    it.last   = last;
    pending_items.push_back(it);
    queued_count++;
  endtask

  task automatic write_setting(input logic idx, input logic [31:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_BASE_INC) begin
      model_base_inc = value;
    end else begin
      model_count = value[4:0];
    end
  endtask

  task automatic drain_and_settle();
    while (accepted_count != queued_count || expected_samples.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_gap = 0;
    end else if (!in_tvalid || in_tready) begin
      if (in_gap == 0 && !quiet && $urandom_range(0, 11) == 0) begin
        in_gap = $urandom_range(1, 11);
      end
      if (in_gap > 0) begin
        in_gap--;
        in_tvalid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        drive_item = pending_items.pop_front();
        in_tvalid <= 1'b1;
        in_tdata  <= {4'h0, drive_item.prior, drive_item.offset, drive_item.amp,
                      drive_item.ratio, drive_item.pidx};
        in_tuser  <= drive_item.action;
        in_tlast  <= drive_item.last;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      seen_item.pidx   = in_tdata[3:0];
      seen_item.ratio  = in_tdata[19:4];
      seen_item.amp    = in_tdata[35:20];
      seen_item.offset = in_tdata[51:36];
      seen_item.prior  = in_tdata[67:52];
      seen_item.action = in_tuser;
      seen_item.last   = in_tlast;
      apply_item(seen_item);
      accepted_count++;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      out_gap = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (expected_samples.size() == 0) begin
          $display("%0t unexpected transfer: expected none, actual sample %h index %h",
                   $time, out_tdata[15:0], out_tdata[47:16]);
          fail_count++;
        end else begin
          want = expected_samples.pop_front();
          if (out_tdata[15:0] !== want.sample) begin
            $display("%0t sample mismatch: expected %h actual %h",
                     $time, want.sample, out_tdata[15:0]);
            fail_count++;
          end
          if (out_tdata[47:16] !== want.index) begin
            $display("%0t sample_index mismatch: expected %h actual %h",
                     $time, want.index, out_tdata[47:16]);
            fail_count++;
          end
        end
      end
      if (out_gap == 0 && !quiet && $urandom_range(0, 7) == 0) begin
        out_gap = $urandom_range(1, 11);
      end
      if (out_gap > 0) begin
        out_gap--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("additive_sine_synth_core regression: fail");
        $finish;
      end
    end
  end

  initial begin
    int          ph;
    int          j;
    int          entry;
    logic [15:0] amp;
    logic [31:0] base;
    logic [31:0] count;
    build_quarter_wave();
    model_base_inc = '0;
    model_count    = '0;
    model_counter  = '0;
    for (entry = 0; entry < MAX_PARTIALS; entry++) begin
      ratio_mem[entry]  = '0;
      amp_mem[entry]    = '0;
      offset_mem[entry] = '0;
      phase_acc[entry]  = '0;
    end
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // no active partials: sample is the prior, block end resets the index
    queue_gen(16'h7FFF, 1'b0);
    queue_gen(16'h8000, 1'b1);
    queue_load(4'd0, 16'h0100, 16'h7FFF, 16'h0000);
    queue_load(4'd1, 16'hFFFF, 16'h8000, 16'hFFFF);
    queue_load(4'd2, 16'h0000, 16'h4000, 16'h4000);
    for (entry = 3; entry < MAX_PARTIALS; entry++) begin
      queue_load(4'(entry), 16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)),
                 16'($urandom_range(0, 65535)));
    end
    drain_and_settle();

    // single partial at its peaks: saturate both ways
    write_setting(CFG_BASE_INC, 32'h0400_0000);
    write_setting(CFG_PARTIAL_CNT, 32'd1);
    queue_load(4'd0, 16'h0100, 16'h7FFF, 16'h4000);
    queue_gen(16'h7FFF, 1'b0);
    queue_gen(16'h0000, 1'b0);
    queue_load(4'd0, 16'h0100, 16'h7FFF, 16'hC000);
    queue_gen(16'h8000, 1'b0);
    queue_gen(16'h0000, 1'b1);
    drain_and_settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0:       begin base = 32'hFFFF_FFFF; count = 32'd16; end
        1:       begin base = 32'h0000_0000; count = 32'd31; end
        2:       begin base = $urandom; count = 32'd17; end
        3:       begin base = $urandom; count = 32'd1; end
        4:       begin base = $urandom_range(0, 32'h00FF_FFFF); count = 32'd0; end
        default: begin base = $urandom; count = $urandom_range(0, 31); end
      endcase
      if (ph == PHASES - 1) begin
        quiet = 1'b1;
      end
      write_setting(CFG_BASE_INC, base);
      write_setting(CFG_PARTIAL_CNT, count);
      for (j = 0; j < PHASE_ITEMS; j++) begin
        if ($urandom_range(0, 4) == 0) begin
          if ($urandom_range(0, 1) == 0) begin
            amp = 16'($urandom_range(0, 65535));
          end else begin
            amp = 16'($urandom_range(0, 4095)) - 16'd2048;
          end
          queue_load(4'($urandom_range(0, 15)), 16'($urandom_range(0, 65535)), amp,
                     16'($urandom_range(0, 65535)));
        end else begin
          queue_gen(16'($urandom_range(0, 65535)), $urandom_range(0, 19) == 0);
        end
      end
      drain_and_settle();
    end

    if (fail_count == 0) begin
      $display("additive_sine_synth_core regression: pass");
    end else begin
      $display("additive_sine_synth_core regression: fail");
    end
    $finish;
  end

endmodule
